[hdl/lpft_pkg.sv]
// ----------------------------------------------------------------------------
// lpft_pkg
// Shared types and constants of the LRU page frame tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package lpft_pkg;

    localparam int IDX_W       = 6;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 56;
    localparam int OUT_TUSER_W = 2;
    localparam int CFG_W       = 5;
    localparam int FAULT_W     = 32;
    localparam int OUT_PAGE_W  = 16;
    localparam int OUT_FRAME_W = 4;

    localparam logic [CFG_W-1:0] CFG_RESET = 5'd3;

    // lookup result rippling from cell 0 upward
    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] hit_idx;
        logic [IDX_W-1:0] hit_rank;
        logic [IDX_W-1:0] vic_idx;
    } lpft_scan_t;

    // update command broadcast to every cell
    typedef struct packed {
        logic             en;
        logic             clear;
        logic             fill;
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] old_rank;
    } lpft_upd_t;

endpackage

`default_nettype wire

[hdl/lru_page_frame_tracker_unit.sv]
// ----------------------------------------------------------------------------
// lru_page_frame_tracker_unit
// LRU page replacement over a row of frame cells with per-frame age ranks.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                                      | side
//  s_      | in  | [15:0] page_number                         | tlast last_access
//  m_      | out | [3:0] frame, [19:4] evicted_page, [51:20]  | tuser {evicted,hit}
//          |     | fault_total                                | tlast trace_done
//  cfg_    | in  | [4:0] frames_in_use                        | cfg_wr_en
//
//  a lookup state through the cell chain, then a rank update state in every
//  cell that already takes the next reference; result registered after lookup
//  a held result stalls the lookup until it is taken
//  reset is synchronous; no clearing pass
//  a transfer with tlast returns all trace state to reset after its result
// ----------------------------------------------------------------------------
`default_nettype none

module lru_page_frame_tracker_unit
    import lpft_pkg::*;
#(
    parameter int FRAMES    = 16,
    parameter int PAGE_BITS = 16
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_W-1:0]       cfg_wr_data,  // frames_in_use
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,      // page_number
    input  wire logic                   s_tlast,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata,      // frame_index, evicted_page, fault_total
    output logic [OUT_TUSER_W-1:0]      m_tuser,      // hit, evicted
    output logic                        m_tlast
);

    localparam int RANK_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int FILL_W = $clog2(FRAMES + 1);
    localparam int CMP_W  = (FILL_W > CFG_W) ? FILL_W : CFG_W;
    localparam logic [CMP_W-1:0] FRAMES_C = CMP_W'(FRAMES);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_UPDATE
    } state_t;

    state_t                  state_reg, state_next;
    logic [PAGE_BITS-1:0]    key_reg, key_next;
    logic                    last_reg, last_next;
    logic [CFG_W-1:0]        cap_reg;
    logic [FILL_W-1:0]       filled_reg, filled_next;
    logic [FAULT_W-1:0]      faults_reg, faults_next;
    lpft_upd_t               upd_reg, upd_next;
    logic                    m_valid_reg, m_valid_next;
    logic [OUT_TDATA_W-1:0]  m_data_reg, m_data_next;
    logic [OUT_TUSER_W-1:0]  m_user_reg, m_user_next;
    logic                    m_last_reg, m_last_next;

    lpft_scan_t              scan [0:FRAMES];
    logic [PAGE_BITS-1:0]    vpage [0:FRAMES];
    lpft_upd_t               upd_cell;
    logic [IDX_W-1:0]        victim_rank;
    logic [PAGE_BITS-1:0]    in_page;
    logic [OUT_PAGE_W-1:0]   vic_page_out;
    logic [CMP_W-1:0]        cfg_ext;
    logic [CMP_W-1:0]        cap;
    logic                    do_fill;
    logic                    do_evict;
    logic [IDX_W-1:0]        frame;
    logic                    in_xfer;

    generate
        if (PAGE_BITS >= IN_TDATA_W) begin : g_wide
            assign in_page      = PAGE_BITS'(s_tdata);
            assign vic_page_out = vpage[FRAMES][OUT_PAGE_W-1:0];
        end else begin : g_narrow
            assign in_page      = s_tdata[PAGE_BITS-1:0];
            assign vic_page_out = OUT_PAGE_W'(vpage[FRAMES]);
        end
    endgenerate

    assign scan[0]  = '0;
    assign vpage[0] = '0;
    assign victim_rank = IDX_W'(filled_reg) - IDX_W'(1);

    always_comb begin
        upd_cell    = upd_reg;
        upd_cell.en = upd_reg.en && (state_reg == ST_UPDATE);
    end

    genvar gi;
    generate
        for (gi = 0; gi < FRAMES; gi++) begin : g_cell
            lpft_cell #(
                .IDX    (gi),
                .PAGE_W (PAGE_BITS),
                .RANK_W (RANK_W)
            ) u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .key         (key_reg),
                .victim_rank (victim_rank),
                .upd         (upd_cell),
                .scan_in     (scan[gi]),
                .vpage_in    (vpage[gi]),
                .scan_out    (scan[gi+1]),
                .vpage_out   (vpage[gi+1])
            );
        end
    endgenerate

    assign cfg_ext  = CMP_W'(cap_reg);
    assign cap      = (cfg_ext == '0) ? CMP_W'(1) :
                      ((cfg_ext > FRAMES_C) ? FRAMES_C : cfg_ext);
    assign do_fill  = !scan[FRAMES].hit && (CMP_W'(filled_reg) < cap);
    assign do_evict = !scan[FRAMES].hit && !do_fill;
    assign frame    = scan[FRAMES].hit ? scan[FRAMES].hit_idx :
                      (do_fill ? IDX_W'(filled_reg) : scan[FRAMES].vic_idx);
    assign in_xfer  = s_tvalid && s_tready;

    always_comb begin
        state_next   = state_reg;
        key_next     = key_reg;
        last_next    = last_reg;
        filled_next  = filled_reg;
        faults_next  = faults_reg;
        upd_next     = upd_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        m_last_next  = m_last_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE, ST_UPDATE: begin
                if (in_xfer) begin
                    key_next   = in_page;
                    last_next  = s_tlast;
                    state_next = ST_LOOKUP;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_LOOKUP: begin
                if (!m_valid_reg || m_tready) begin
                    if (!scan[FRAMES].hit && (faults_reg != '1)) begin
                        faults_next = faults_reg + FAULT_W'(1);
                    end
                    if (do_fill) begin
                        filled_next = filled_reg + FILL_W'(1);
                    end
                    m_valid_next = 1'b1;
                    m_user_next  = {do_evict, scan[FRAMES].hit};
                    m_last_next  = last_reg;
                    m_data_next  = OUT_TDATA_W'({faults_next,
                                                 (do_evict ? vic_page_out
                                                           : {OUT_PAGE_W{1'b0}}),
                                                 frame[OUT_FRAME_W-1:0]});
                    upd_next.en       = 1'b1;
                    upd_next.clear    = last_reg;
                    upd_next.fill     = do_fill;
                    upd_next.idx      = frame;
                    upd_next.old_rank = scan[FRAMES].hit ? scan[FRAMES].hit_rank :
                                        (do_fill ? IDX_W'(filled_reg) : victim_rank);
                    if (last_reg) begin
                        filled_next = '0;
                        faults_next = '0;
                    end
                    state_next = ST_UPDATE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cap_reg     <= CFG_RESET;
            filled_reg  <= '0;
            faults_reg  <= '0;
            upd_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            filled_reg  <= filled_next;
            faults_reg  <= faults_next;
            upd_reg     <= upd_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
        end
        key_reg    <= key_next;
        last_reg   <= last_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
        m_last_reg <= m_last_next;
    end

    assign s_tready = (state_reg == ST_IDLE) || (state_reg == ST_UPDATE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

endmodule

`default_nettype wire

[hdl/lpft_cell.sv]
// ----------------------------------------------------------------------------
// lpft_cell
// One frame: page, age rank and valid bit; extends the lookup chain.
// ----------------------------------------------------------------------------
`default_nettype none

module lpft_cell
    import lpft_pkg::*;
#(
    parameter int IDX     = 0,
    parameter int PAGE_W  = 16,
    parameter int RANK_W  = 4
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic [PAGE_W-1:0] key,
    input  wire logic [IDX_W-1:0]  victim_rank,
    input  wire lpft_upd_t         upd,
    input  wire lpft_scan_t        scan_in,
    input  wire logic [PAGE_W-1:0] vpage_in,
    output lpft_scan_t             scan_out,
    output logic [PAGE_W-1:0]      vpage_out
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic [PAGE_W-1:0] page_reg;
    logic [RANK_W-1:0] rank_reg;
    logic              valid_reg;
    logic              match;
    logic              is_vic;
    logic [IDX_W-1:0]  rank_ext;

    assign rank_ext = IDX_W'(rank_reg);
    assign match    = valid_reg && (page_reg == key);
    assign is_vic   = valid_reg && (rank_ext == victim_rank);

    always_comb begin
        scan_out  = scan_in;
        vpage_out = vpage_in;
        if (match && !scan_in.hit) begin
            scan_out.hit      = 1'b1;
            scan_out.hit_idx  = MY_IDX;
            scan_out.hit_rank = rank_ext;
        end
        if (is_vic) begin
            scan_out.vic_idx = MY_IDX;
            vpage_out        = page_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (upd.en && upd.clear)) begin
            valid_reg <= 1'b0;
            rank_reg  <= '0;
        end else if (upd.en) begin
            if (upd.idx == MY_IDX) begin
                rank_reg <= '0;
                if (upd.fill) begin
                    valid_reg <= 1'b1;
                end
            end else if (valid_reg && (rank_ext < upd.old_rank)) begin
                rank_reg <= rank_reg + RANK_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (upd.en && !upd.clear && (upd.idx == MY_IDX)) begin
            page_reg <= key;
        end
    end

endmodule

`default_nettype wire

[hdl/lpft_checker.sv]
// ----------------------------------------------------------------------------
// lpft_checker
// Port-level checks of the LRU page frame tracker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lpft_checker
    import lpft_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    input  wire logic                   s_tready,
    input  wire logic                   m_tvalid,
    input  wire logic                   m_tready,
    input  wire logic [OUT_TDATA_W-1:0] m_tdata,
    input  wire logic [OUT_TUSER_W-1:0] m_tuser
);

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken during lookup");

    a_hit_no_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("hit reported together with eviction");

    a_evict_page_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[1]) |-> (m_tdata[19:4] == '0))
        else $error("evicted page nonzero without eviction");

    a_hold_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("result changed while stalled");

endmodule

bind lru_page_frame_tracker_unit lpft_checker u_lpft_checker (.*);

`default_nettype wire

[bench/tb_lru_page_frame_tracker_unit.sv]
// ----------------------------------------------------------------------------
// tb_lru_page_frame_tracker_unit
// Self-checking bench for the LRU page frame tracker. A table of directed
// page references (reset state, frame count extremes, eviction, end of trace,
// frame count lowered mid-trace) runs first. Random traces over small page
// working sets follow, under several frame counts. Every result transfer is
// checked field by field against the table's expected fields or an in-bench
// LRU predictor. Both stream sides idle at random outside one calm phase.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_lru_page_frame_tracker_unit;
    import lpft_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAME_SLOTS = 16;
    localparam int PAGE_W      = 16;

    typedef struct packed {
        logic                   hit;
        logic [OUT_FRAME_W-1:0] frame;
        logic                   evicted;
        logic [OUT_PAGE_W-1:0]  evicted_page;
        logic [FAULT_W-1:0]     fault_total;
        logic                   trace_done;
    } access_result_t;

    typedef struct {
        bit                 is_cfg;
        logic [CFG_W-1:0]   cfg_val;
        logic [PAGE_W-1:0]  page;
        logic               last;
        bit                 typed;
        access_result_t     want;
    } ref_row_t;

    logic                   aclk        = 1'b0;
    logic                   aresetn     = 1'b0;
    logic                   cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0]       cfg_wr_data = '0;
    logic                   s_tvalid    = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata     = '0;  // page_number
    logic                   s_tlast     = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready    = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;           // frame_index, evicted_page, fault_total
    logic [OUT_TUSER_W-1:0] m_tuser;           // hit, evicted
    logic                   m_tlast;

    // predictor state
    logic [PAGE_W-1:0]      frame_page [FRAME_SLOTS];
    int                     frame_rank [FRAME_SLOTS];
    int                     frames_filled = 0;
    logic [FAULT_W-1:0]     fault_count   = '0;
    logic [CFG_W-1:0]       frame_limit   = CFG_RESET;

    access_result_t         expected_results [$];
    int                     errors = 0;
    bit                     calm   = 1'b0;

    lru_page_frame_tracker_unit #(
        .FRAMES    (FRAME_SLOTS),
        .PAGE_BITS (PAGE_W)
    ) i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    always #6 aclk = ~aclk;

    initial begin
        #5_000_000;
        $display("tb_lru_page_frame_tracker_unit: done, errors");
        $finish;
    end

    always @(posedge aclk) begin
        m_tready <= calm || ($urandom_range(0, 99) >= 17);
    end

    task automatic report_mismatch(input string msg);
        $display("tb: mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    // mark frame f most recent, age every filled frame younger than it
    function automatic void make_newest(input int f);
        int old_rank;
        old_rank = frame_rank[f];
        for (int i = 0; i < frames_filled; i++) begin
            if (i != f && frame_rank[i] < old_rank) begin
                frame_rank[i]++;
            end
        end
        frame_rank[f] = 0;
    endfunction

    function automatic access_result_t lru_access(input logic [PAGE_W-1:0] page,
                                                  input logic last);
        access_result_t r;
        int             cap;
        int             f;
        bit             found;
        r     = '0;
        f     = 0;
        found = 1'b0;
        cap   = int'(frame_limit);
        if (cap < 1) begin
            cap = 1;
        end
        if (cap > FRAME_SLOTS) begin
            cap = FRAME_SLOTS;
        end
        for (int i = 0; i < frames_filled; i++) begin
            if (!found && frame_page[i] == page) begin
                f     = i;
                found = 1'b1;
            end
        end
        if (found) begin
            make_newest(f);
        end else begin
            if (fault_count != '1) begin
                fault_count++;
            end
            if (frames_filled < cap) begin
                f             = frames_filled;
                frame_page[f] = page;
                frame_rank[f] = frames_filled;
                frames_filled++;
                make_newest(f);
            end else begin
                for (int i = 1; i < frames_filled; i++) begin
                    if (frame_rank[i] > frame_rank[f]) begin
                        f = i;
                    end
                end
                r.evicted      = 1'b1;
                r.evicted_page = frame_page[f];
                frame_page[f]  = page;
                make_newest(f);
            end
        end
        r.hit         = found;
        r.frame       = f[OUT_FRAME_W-1:0];
        r.fault_total = fault_count;
        r.trace_done  = last;
        if (last) begin
            for (int i = 0; i < FRAME_SLOTS; i++) begin
                frame_page[i] = '0;
                frame_rank[i] = 0;
            end
            frames_filled = 0;
            fault_count   = '0;
        end
        return r;
    endfunction

    task automatic send_ref(input logic [PAGE_W-1:0] page, input logic last,
                            input bit typed, input access_result_t given);
        access_result_t predicted;
        s_tvalid <= 1'b1;
        s_tdata  <= page;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        predicted = lru_access(page, last);
        expected_results.push_back(typed ? given : predicted);
        if (!calm && $urandom_range(0, 99) < 17) begin
            s_tvalid <= 1'b0;
            do begin
                @(posedge aclk);
            end while ($urandom_range(0, 99) < 17);
        end
    endtask

    // let all results drain, then write the frame count
    task automatic set_frame_limit(input logic [CFG_W-1:0] value);
        s_tvalid <= 1'b0;
        wait (expected_results.size() == 0);
        repeat (4) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        frame_limit  = value;
    endtask

    always @(posedge aclk) begin : result_check
        access_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result transfer with nothing expected");
            end else begin
                want = expected_results.pop_front();
                if (m_tuser[0] !== want.hit) begin
                    report_mismatch($sformatf("hit got %0b want %0b", m_tuser[0], want.hit));
                end
                if (m_tdata[3:0] !== want.frame) begin
                    report_mismatch($sformatf("frame got %0d want %0d",
                                              m_tdata[3:0], want.frame));
                end
                if (m_tuser[1] !== want.evicted) begin
                    report_mismatch($sformatf("evicted got %0b want %0b",
                                              m_tuser[1], want.evicted));
                end
                if (m_tdata[19:4] !== want.evicted_page) begin
                    report_mismatch($sformatf("evicted_page got %h want %h",
                                              m_tdata[19:4], want.evicted_page));
                end
                if (m_tdata[51:20] !== want.fault_total) begin
                    report_mismatch($sformatf("fault_total got %0d want %0d",
                                              m_tdata[51:20], want.fault_total));
                end
                if (m_tlast !== want.trace_done) begin
                    report_mismatch($sformatf("trace_done got %0b want %0b",
                                              m_tlast, want.trace_done));
                end
            end
        end
    end

    initial begin
        ref_row_t          rows [$];
        logic [PAGE_W-1:0] pool [$];
        logic [PAGE_W-1:0] page;
        logic [CFG_W-1:0]  plan [8];
        access_result_t    none;
        int                sent;
        int                phase;
        int                span;
        int                cap;
        int                pick;

        plan = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd2, 5'd8, 5'd17, 5'd4};
        none = '0;
        for (int i = 0; i < FRAME_SLOTS; i++) begin
            frame_page[i] = '0;
            frame_rank[i] = 0;
        end

        // three frames after reset
        rows.push_back('{0, '0, 16'h0000, 1'b0, 1, '{1'b0, 4'd0, 1'b0, 16'h0, 32'd1, 1'b0}});
        rows.push_back('{0, '0, 16'hFFFF, 1'b0, 1, '{1'b0, 4'd1, 1'b0, 16'h0, 32'd2, 1'b0}});
        rows.push_back('{0, '0, 16'h0000, 1'b0, 1, '{1'b1, 4'd0, 1'b0, 16'h0, 32'd2, 1'b0}});
        rows.push_back('{0, '0, 16'h1234, 1'b0, 1, '{1'b0, 4'd2, 1'b0, 16'h0, 32'd3, 1'b0}});
        rows.push_back('{0, '0, 16'h8000, 1'b0, 1, '{1'b0, 4'd1, 1'b1, 16'hFFFF, 32'd4, 1'b0}});
        rows.push_back('{0, '0, 16'h1234, 1'b0, 1, '{1'b1, 4'd2, 1'b0, 16'h0, 32'd4, 1'b0}});
        // eviction of page zero closes the trace
        rows.push_back('{0, '0, 16'h0001, 1'b1, 1, '{1'b0, 4'd0, 1'b1, 16'h0000, 32'd5, 1'b1}});
        rows.push_back('{0, '0, 16'h5555, 1'b0, 1, '{1'b0, 4'd0, 1'b0, 16'h0, 32'd1, 1'b0}});
        // zero frames acts as one
        rows.push_back('{1, 5'd0, '0, 1'b0, 0, none});
        rows.push_back('{0, '0, 16'hAAAA, 1'b0, 1, '{1'b0, 4'd0, 1'b1, 16'h5555, 32'd2, 1'b0}});
        rows.push_back('{0, '0, 16'hAAAA, 1'b0, 1, '{1'b1, 4'd0, 1'b0, 16'h0, 32'd2, 1'b0}});
        // above the frame count clamps to all frames
        rows.push_back('{1, 5'd31, '0, 1'b0, 0, none});
        rows.push_back('{0, '0, 16'h0101, 1'b0, 0, none});
        rows.push_back('{0, '0, 16'h0202, 1'b0, 0, none});
        rows.push_back('{0, '0, 16'h0404, 1'b0, 0, none});
        rows.push_back('{0, '0, 16'h0808, 1'b0, 0, none});
        rows.push_back('{0, '0, 16'h7FFF, 1'b0, 0, none});
        // lowered mid-trace, eviction still over all six held pages
        rows.push_back('{1, 5'd2, '0, 1'b0, 0, none});
        rows.push_back('{0, '0, 16'h1000, 1'b0, 1, '{1'b0, 4'd0, 1'b1, 16'hAAAA, 32'd8, 1'b0}});
        rows.push_back('{0, '0, 16'h0202, 1'b0, 0, none});
        rows.push_back('{1, 5'd16, '0, 1'b0, 0, none});
        rows.push_back('{0, '0, 16'h2000, 1'b0, 0, none});
        rows.push_back('{0, '0, 16'hFFFF, 1'b1, 0, none});
        rows.push_back('{1, 5'd1, '0, 1'b0, 0, none});
        rows.push_back('{0, '0, 16'hC3C3, 1'b0, 1, '{1'b0, 4'd0, 1'b0, 16'h0, 32'd1, 1'b0}});
        rows.push_back('{0, '0, 16'h3C3C, 1'b1, 1, '{1'b0, 4'd0, 1'b1, 16'hC3C3, 32'd2, 1'b1}});

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[n]) begin
            if (rows[n].is_cfg) begin
                set_frame_limit(rows[n].cfg_val);
            end else begin
                send_ref(rows[n].page, rows[n].last, rows[n].typed, rows[n].want);
            end
        end

        // random traces over small working sets, one frame count per phase
        sent  = 0;
        phase = 0;
        while (sent < 1200) begin
            set_frame_limit(phase < 8 ? plan[phase] : 5'($urandom_range(0, 31)));
            calm = (phase == 2);
            cap  = (frame_limit == 0) ? 1 : (frame_limit > FRAME_SLOTS) ? FRAME_SLOTS
                                                                        : int'(frame_limit);
            pool.delete();
            span = cap + $urandom_range(0, 4);
            for (int i = 0; i < span; i++) begin
                pool.push_back(PAGE_W'($urandom));
            end
            span = $urandom_range(40, 150);
            for (int k = 0; k < span; k++) begin
                if (phase == 3 && k == 20) begin
                    s_tvalid <= 1'b0;
                    wait (expected_results.size() == 0);
                    @(posedge aclk);
                end
                pick = $urandom_range(0, 99);
                if (pick < 85) begin
                    page = pool[$urandom_range(0, pool.size() - 1)];
                end else if (pick < 95) begin
                    page = PAGE_W'($urandom);
                end else begin
                    page = pick[0] ? '1 : '0;
                end
                send_ref(page, $urandom_range(0, 29) == 0, 0, none);
                sent++;
            end
            phase++;
        end
        calm = 1'b0;

        s_tvalid <= 1'b0;
        wait (expected_results.size() == 0);
        repeat (10) @(posedge aclk);
        if (errors == 0) begin
            $display("tb_lru_page_frame_tracker_unit: done, clean");
        end else begin
            $display("tb_lru_page_frame_tracker_unit: done, errors");
        end
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
hdl/lpft_pkg.sv
hdl/lpft_cell.sv
hdl/lru_page_frame_tracker_unit.sv
hdl/lpft_checker.sv
bench/tb_lru_page_frame_tracker_unit.sv
